/* sv/mwsd_pkg.sv */
// ----------------------------------------------------------------------------
// mwsd_pkg
// Types and fixed field widths shared by the moving window deviation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsd_pkg;

    localparam int ALT_W       = 27;
    localparam int DEV_W       = 27;
    localparam int SCALED_W    = 30;
    localparam int SIGMA_W     = 8;
    localparam int FRAC_BITS   = 4;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 8'd48;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_FILL = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_DIFF,
        ST_ROOT,
        ST_SCALE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

endpackage

`default_nettype wire

/* sv/mwsd_if.sv */
// ----------------------------------------------------------------------------
// mwsd channel interfaces
// Valid/ready channels for samples, results and the sigma factor register.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwsd_sample_if import mwsd_pkg::*;;
    logic                    valid;
    logic                    ready;
    op_t                     operation;
    logic signed [ALT_W-1:0] altitude_mm;

    modport source (output valid, output operation, output altitude_mm, input ready);
    modport sink   (input valid, input operation, input altitude_mm, output ready);
endinterface

interface mwsd_result_if import mwsd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [DEV_W-1:0]    deviation_mm;
    logic [SCALED_W-1:0] scaled_deviation_mm;

    modport source (output valid, output deviation_mm, output scaled_deviation_mm,
                    input ready);
    modport sink   (input valid, input deviation_mm, input scaled_deviation_mm,
                    output ready);
endinterface

interface mwsd_cfg_if import mwsd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SIGMA_W-1:0] sigma_factor;

    modport source (output valid, output sigma_factor, input ready);
    modport sink   (input valid, input sigma_factor, output ready);
endinterface

`default_nettype wire

/* sv/moving_window_std_deviation_core.sv */
// ----------------------------------------------------------------------------
// moving_window_std_deviation_core
// Population standard deviation over a sliding window of altitude samples.
// ----------------------------------------------------------------------------
// Each sample item either pushes one altitude into the window or fills every
// slot with it, and yields one result item: floor(sqrt(W*sum_sq - sum^2)/W)
// and that root scaled by sigma_factor/16 and divided by W. Running sum and
// sum of squares are updated per item; the squares come from a radix-4
// shift-add multiplier, the root from a one-bit-per-cycle square root unit
// and the divisions by W from a one-bit-per-cycle restoring divider. One item
// is processed at a time, and the next item can be accepted in the cycle after
// the result is loaded. A finished result waits in an output register while
// the next item is already accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_window_std_deviation_core import mwsd_pkg::*; #(
    parameter int WINDOW = 5
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mwsd_sample_if.sink    sample,
    mwsd_result_if.source  result,
    mwsd_cfg_if.sink       cfg
);

    localparam int WIN_W  = $clog2(WINDOW);
    localparam int MAG_W  = ALT_W + WIN_W;
    localparam int SUM_W  = MAG_W + 1;
    localparam int SQ_W   = 2 * ALT_W;
    localparam int SSQ_W  = SQ_W + WIN_W;
    localparam int DIFF_W = SSQ_W + WIN_W;
    localparam int ROOT_W = (DIFF_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int PROD_W = ROOT_W + SIGMA_W;
    localparam int QUO_W  = PROD_W - FRAC_BITS;
    localparam int DIG_N  = (MAG_W + 1) / 2;
    localparam int MUL_W  = 2 * DIG_N;
    localparam int ACC_W  = 2 * MUL_W;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    localparam logic [WIN_W:0]            WIN_C    = (WIN_W + 1)'(WINDOW);
    localparam logic signed [SUM_W-1:0]   WIN_SUM  = SUM_W'(WINDOW);
    localparam logic [SSQ_W-1:0]          WIN_SSQ  = SSQ_W'(WINDOW);
    localparam logic [DIFF_W-1:0]         WIN_DIFF = DIFF_W'(WINDOW);

    state_t state_reg, state_next;

    logic [SIGMA_W-1:0]      sigma_reg;
    op_t                     op_reg;
    logic signed [ALT_W-1:0] win_reg [WINDOW];
    logic [SQ_W-1:0]         sq_reg  [WINDOW];
    logic signed [SUM_W-1:0] sum_reg;
    logic [SSQ_W-1:0]        ssq_reg;
    logic [CNT_W-1:0]        cnt_reg;

    // two squarers run side by side: sample magnitude and sum magnitude
    logic [ACC_W-1:0] a_mc_reg, a_acc_reg, s_mc_reg, s_acc_reg;
    logic [MUL_W-1:0] a_mp_reg, s_mp_reg;

    logic [QUO_W-1:0] div1_reg, div2_reg;
    logic [WIN_W-1:0] rem1_reg, rem2_reg;

    logic                out_valid_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [SCALED_W-1:0] scl_reg;

    logic                    accept;
    logic                    out_load;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       root;
    logic signed [SUM_W-1:0] alt_ext;
    logic signed [SUM_W-1:0] sum_new;
    logic [ALT_W-1:0]        alt_mag;
    logic [MAG_W-1:0]        sum_mag;
    logic [SQ_W-1:0]         asq;
    logic [DIFF_W-1:0]       diff;
    logic [PROD_W-1:0]       prod;
    logic [ACC_W-1:0]        a_add, s_add;
    logic [WIN_W:0]          t1, t2;

    assign accept     = sample.valid && sample.ready;
    assign out_load   = (state_reg == ST_OUTPUT) && (!out_valid_reg || result.ready);
    assign sqrt_start = (state_reg == ST_DIFF);

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign result.valid               = out_valid_reg;
    assign result.deviation_mm        = dev_reg;
    assign result.scaled_deviation_mm = scl_reg;

    always_comb
    begin
        alt_ext = {{(SUM_W - ALT_W){sample.altitude_mm[ALT_W-1]}}, sample.altitude_mm};
        alt_mag = sample.altitude_mm[ALT_W-1] ? ALT_W'(-sample.altitude_mm)
                                              : ALT_W'(sample.altitude_mm);
        if (sample.operation == OP_FILL)
            sum_new = alt_ext * WIN_SUM;
        else
            sum_new = sum_reg - SUM_W'(win_reg[0]) + alt_ext;
        sum_mag = sum_new[SUM_W-1] ? MAG_W'(-sum_new) : MAG_W'(sum_new);

        // radix-4 partial products
        a_add = (a_mp_reg[0] ? a_mc_reg : '0) + (a_mp_reg[1] ? {a_mc_reg[ACC_W-2:0], 1'b0} : '0);
        s_add = (s_mp_reg[0] ? s_mc_reg : '0) + (s_mp_reg[1] ? {s_mc_reg[ACC_W-2:0], 1'b0} : '0);

        asq  = SQ_W'(a_acc_reg);
        diff = DIFF_W'(ssq_reg) * WIN_DIFF - DIFF_W'(s_acc_reg);
        prod = PROD_W'(root) * PROD_W'(sigma_reg);

        t1 = {rem1_reg, div1_reg[QUO_W-1]};
        t2 = {rem2_reg, div2_reg[QUO_W-1]};
    end

    mwsd_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (RAD_W'(diff)),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_SQUARE;
            ST_SQUARE:
                if (cnt_reg == CNT_W'(DIG_N - 1))
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = ST_DIFF;
            ST_DIFF:
                state_next = ST_ROOT;
            ST_ROOT:
                if (sqrt_done)
                    state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (cnt_reg == CNT_W'(QUO_W - 1))
                    state_next = ST_OUTPUT;
            ST_OUTPUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control state, configuration and window contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= SIGMA_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ssq_reg       <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                sigma_reg <= cfg.sigma_factor;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (accept || state_reg == ST_SCALE)
                cnt_reg <= '0;
            else if (state_reg == ST_SQUARE || state_reg == ST_DIVIDE)
                cnt_reg <= cnt_reg + 1'b1;

            if (accept)
            begin
                sum_reg <= sum_new;
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    if (sample.operation == OP_FILL)
                        win_reg[i] <= sample.altitude_mm;
                    else
                        win_reg[i] <= win_reg[i + 1];
                end
                win_reg[WINDOW - 1] <= sample.altitude_mm;
            end

            // squares lag the samples by the multiply time
            if (state_reg == ST_UPDATE)
            begin
                if (op_reg == OP_FILL)
                    ssq_reg <= SSQ_W'(asq) * WIN_SSQ;
                else
                    ssq_reg <= ssq_reg - SSQ_W'(sq_reg[0]) + SSQ_W'(asq);
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    if (op_reg == OP_FILL)
                        sq_reg[i] <= asq;
                    else
                        sq_reg[i] <= sq_reg[i + 1];
                end
                sq_reg[WINDOW - 1] <= asq;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= sample.operation;
            a_mc_reg  <= ACC_W'(alt_mag);
            a_mp_reg  <= MUL_W'(alt_mag);
            a_acc_reg <= '0;
            s_mc_reg  <= ACC_W'(sum_mag);
            s_mp_reg  <= MUL_W'(sum_mag);
            s_acc_reg <= '0;
        end
        else if (state_reg == ST_SQUARE)
        begin
            a_acc_reg <= a_acc_reg + a_add;
            s_acc_reg <= s_acc_reg + s_add;
            a_mc_reg  <= {a_mc_reg[ACC_W-3:0], 2'b00};
            s_mc_reg  <= {s_mc_reg[ACC_W-3:0], 2'b00};
            a_mp_reg  <= {2'b00, a_mp_reg[MUL_W-1:2]};
            s_mp_reg  <= {2'b00, s_mp_reg[MUL_W-1:2]};
        end

        if (state_reg == ST_SCALE)
        begin
            div1_reg <= QUO_W'(root);
            div2_reg <= prod[PROD_W-1:FRAC_BITS];
            rem1_reg <= '0;
            rem2_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            // restoring division by the window length, quotient shifts in below
            if (t1 >= WIN_C)
            begin
                rem1_reg <= WIN_W'(t1 - WIN_C);
                div1_reg <= {div1_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem1_reg <= t1[WIN_W-1:0];
                div1_reg <= {div1_reg[QUO_W-2:0], 1'b0};
            end
            if (t2 >= WIN_C)
            begin
                rem2_reg <= WIN_W'(t2 - WIN_C);
                div2_reg <= {div2_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem2_reg <= t2[WIN_W-1:0];
                div2_reg <= {div2_reg[QUO_W-2:0], 1'b0};
            end
        end

        if (out_load)
        begin
            dev_reg <= div1_reg[DEV_W-1:0];
            scl_reg <= div2_reg[SCALED_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* sv/mwsd_isqrt.sv */
// ----------------------------------------------------------------------------
// mwsd_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsd_isqrt #(
    parameter int ROOT_W = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output logic                       done,
    output logic [ROOT_W-1:0]          root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        // bring down the next two radicand bits
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};

        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
